// File: hw/rtl/blm_pkg.sv
// Shared widths, reset values and codes of the battery level monitor.
`default_nettype none

package blm_pkg;

  // Field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned MvW     = 16;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned HystW   = 12;
  localparam int unsigned LevelW  = 2;
  localparam int unsigned FiltW   = 24;            // Q16.8 filter store
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 17;

  // Serial unit sizes
  localparam int unsigned MulSteps = MvW;          // gain bits, one per cycle
  localparam int unsigned DivW     = 2 * MvW - 12; // product with Q4.12 fraction dropped
  localparam int unsigned EmaSteps = AlphaW;       // alpha bits, one per cycle
  localparam int unsigned AccW     = FiltW + 3;
  localparam int unsigned CntW     = 5;

  // Default oversampling count
  localparam int unsigned OVERSAMPLE_DEF = 16;

  // Alpha value for one
  localparam logic [AlphaW-1:0] ALPHA_ONE = AlphaW'(65536);

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_V_GOOD   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_V_LOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HYST     = 3'd5;

  // Register reset values
  localparam logic [MvW-1:0]    INTERVAL_RST = 16'd1000;
  localparam logic [MvW-1:0]    GAIN_RST     = 16'd8192;
  localparam logic [AlphaW-1:0] ALPHA_RST    = 17'd6554;
  localparam logic [MvW-1:0]    V_GOOD_RST   = 16'd3600;
  localparam logic [MvW-1:0]    V_LOW_RST    = 16'd3400;
  localparam logic [HystW-1:0]  HYST_RST     = 12'd100;

  // Item modes
  localparam logic [ModeW-1:0] MODE_UPDATE    = 2'd0;
  localparam logic [ModeW-1:0] MODE_SEED      = 2'd1;
  localparam logic [ModeW-1:0] MODE_SIM_SET   = 2'd2;
  localparam logic [ModeW-1:0] MODE_SIM_CLEAR = 2'd3;

  // Battery levels
  localparam logic [LevelW-1:0] LVL_GOOD = 2'd0;
  localparam logic [LevelW-1:0] LVL_WARN = 2'd1;
  localparam logic [LevelW-1:0] LVL_CRIT = 2'd2;
  localparam logic [LevelW-1:0] LVL_BAD  = 2'd3;

endpackage

`default_nettype wire

// File: hw/rtl/blm_if.sv
// Handshake channels of the battery level monitor: input items, results, register writes.
`default_nettype none

interface blm_in_if import blm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [TimeW-1:0]  now_ms;
  logic [MvW-1:0]    reading_sum_mv;
  logic [MvW-1:0]    sim_mv;

  modport source (output valid, mode, now_ms, reading_sum_mv, sim_mv, input ready);
  modport sink   (input valid, mode, now_ms, reading_sum_mv, sim_mv, output ready);
endinterface

interface blm_out_if import blm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MvW-1:0]    filtered_mv;
  logic [MvW-1:0]    raw_mv;
  logic [LevelW-1:0] level;
  logic              simulated;
  logic              sampled;

  modport source (output valid, filtered_mv, raw_mv, level, simulated, sampled,
                  input ready);
  modport sink   (input valid, filtered_mv, raw_mv, level, simulated, sampled,
                  output ready);
endinterface

interface blm_cfg_if import blm_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/battery_level_monitor_top.sv
// Battery level monitor: serial measurement, exponential filter and level classifier.
`default_nettype none

// Takes one item at a time. Set-simulated items and updates that fall inside
// the sample interval go straight to the done state, simulated updates pass
// the classifier state first. Items that measure go through a bit-serial gain
// multiplier and a bit-serial divider by OVERSAMPLE_COUNT: boot seed and
// clear-simulation then classify, a periodic measurement adds the bit-serial
// filter multiply before classifying. A new item is taken while the previous
// result still waits in the output register. Register writes are taken at any
// time but must only be issued while no item is in flight.
module battery_level_monitor_top import blm_pkg::*; #(
  parameter int unsigned OVERSAMPLE_COUNT = OVERSAMPLE_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  blm_cfg_if.sink    cfg_i,
  blm_in_if.sink     in_i,
  blm_out_if.source  out_o
);

  localparam int unsigned OsW = $clog2(OVERSAMPLE_COUNT + 1);
  localparam logic [OsW:0] OsVal = (OsW + 1)'(OVERSAMPLE_COUNT);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_EMA  = 3'd3;
  localparam logic [2:0] ST_CLS  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DivW - 1);
  localparam logic [CntW-1:0] EmaLast = CntW'(EmaSteps - 1);

  // Configuration registers
  logic [MvW-1:0]    interval_q, gain_q, v_good_q, v_low_q;
  logic [AlphaW-1:0] alpha_q;
  logic [HystW-1:0]  hyst_q;

  // Block state
  logic [FiltW-1:0]  filt_q;
  logic [MvW-1:0]    raw_q;
  logic [LevelW-1:0] level_q;
  logic [TimeW-1:0]  last_q;
  logic              sim_q;
  logic [MvW-1:0]    sim_val_q;

  // Sequencer and serial datapath
  logic [2:0]        state_q;
  logic [CntW-1:0]   cnt_q;
  logic [ModeW-1:0]  mode_q;
  logic              sampled_q;
  logic [MvW-1:0]    sum_q;
  logic [AccW-1:0]   acc_q;
  logic [MvW-1:0]    low_q;
  logic [AlphaW-1:0] mplr_q;
  logic [AlphaW-1:0] wcomp_q;
  logic [DivW-1:0]   quo_q;
  logic [OsW-1:0]    rem_q;

  // Output register
  logic              out_valid_q;
  logic [MvW-1:0]    out_filt_q, out_raw_q;
  logic [LevelW-1:0] out_level_q;
  logic              out_sim_q, out_sampled_q;

  logic in_xfer, cfg_xfer, out_free;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_xfer    = cfg_i.valid;
  assign out_free    = !out_valid_q || out_o.ready;

  // Interval check on the incoming time stamp
  logic [TimeW-1:0] elapsed;
  logic             due;
  assign elapsed = in_i.now_ms - last_q;
  assign due     = elapsed >= TimeW'(interval_q);

  // Gain multiply step: add the gain bit's partial product, shift right
  logic [MvW:0] mul_sum;
  assign mul_sum = acc_q[MvW:0] + ((mplr_q[0]) ? {1'b0, sum_q} : '0);

  // Divide step: restoring division by the oversampling count
  logic [OsW:0]    div_trial;
  logic            div_ge;
  logic [OsW-1:0]  div_rem;
  logic [DivW-1:0] div_quo;
  logic [MvW-1:0]  meas_mv;
  assign div_trial = {rem_q, quo_q[DivW-1]};
  assign div_ge    = div_trial >= OsVal;
  assign div_rem   = div_ge ? OsW'(div_trial - OsVal) : div_trial[OsW-1:0];
  assign div_quo   = {quo_q[DivW-2:0], div_ge};
  assign meas_mv   = (|div_quo[DivW-1:MvW]) ? '1 : div_quo[MvW-1:0];

  // Filter step: weights alpha on the measurement, one minus alpha on the store
  logic [AlphaW-1:0] alpha_clamp;
  logic [FiltW-1:0]  meas_q8;
  logic [AccW-1:0]   ema_sum;
  assign alpha_clamp = alpha_q[AlphaW-1] ? ALPHA_ONE : alpha_q;
  assign meas_q8     = {raw_q, 8'd0};
  assign ema_sum     = acc_q + (mplr_q[0] ? AccW'(meas_q8) : '0)
                             + (wcomp_q[0] ? AccW'(filt_q) : '0);

  // Level classifier, steps applied in cascade
  logic [FiltW:0]    f_ext, good_th, low_th, good_up, low_up;
  logic [LevelW-1:0] level_next;
  assign f_ext   = {1'b0, filt_q};
  assign good_th = {1'b0, v_good_q, 8'd0};
  assign low_th  = {1'b0, v_low_q, 8'd0};
  assign good_up = {(MvW + 1)'(v_good_q) + (MvW + 1)'(hyst_q), 8'd0};
  assign low_up  = {(MvW + 1)'(v_low_q) + (MvW + 1)'(hyst_q), 8'd0};

  always_comb begin
    level_next = level_q;
    if (level_next == LVL_GOOD && f_ext < good_th) level_next = LVL_WARN;
    if (level_next == LVL_WARN && f_ext < low_th)  level_next = LVL_CRIT;
    if (level_next == LVL_CRIT && f_ext > low_up)  level_next = LVL_WARN;
    if (level_next == LVL_WARN && f_ext > good_up) level_next = LVL_GOOD;
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      gain_q     <= GAIN_RST;
      alpha_q    <= ALPHA_RST;
      v_good_q   <= V_GOOD_RST;
      v_low_q    <= V_LOW_RST;
      hyst_q     <= HYST_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_i.index)
        REG_INTERVAL: interval_q <= cfg_i.data[MvW-1:0];
        REG_GAIN:     gain_q     <= cfg_i.data[MvW-1:0];
        REG_ALPHA:    alpha_q    <= cfg_i.data[AlphaW-1:0];
        REG_V_GOOD:   v_good_q   <= cfg_i.data[MvW-1:0];
        REG_V_LOW:    v_low_q    <= cfg_i.data[MvW-1:0];
        REG_HYST:     hyst_q     <= cfg_i.data[HystW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state and serial datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      mode_q    <= MODE_UPDATE;
      sampled_q <= 1'b0;
      sum_q     <= '0;
      acc_q     <= '0;
      low_q     <= '0;
      mplr_q    <= '0;
      wcomp_q   <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      filt_q    <= '0;
      raw_q     <= '0;
      level_q   <= LVL_GOOD;
      last_q    <= '0;
      sim_q     <= 1'b0;
      sim_val_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            mode_q    <= in_i.mode;
            sampled_q <= 1'b0;
            sum_q     <= in_i.reading_sum_mv;
            acc_q     <= '0;
            mplr_q    <= {1'b0, gain_q};
            cnt_q     <= '0;
            unique case (in_i.mode)
              MODE_UPDATE: begin
                if (sim_q) begin
                  raw_q   <= sim_val_q;
                  filt_q  <= {sim_val_q, 8'd0};
                  state_q <= ST_CLS;
                end else if (due) begin
                  last_q    <= in_i.now_ms;
                  sampled_q <= 1'b1;
                  state_q   <= ST_MUL;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              MODE_SEED: begin
                last_q    <= in_i.now_ms;
                level_q   <= LVL_GOOD;
                sampled_q <= 1'b1;
                state_q   <= ST_MUL;
              end
              MODE_SIM_SET: begin
                sim_q     <= 1'b1;
                sim_val_q <= in_i.sim_mv;
                state_q   <= ST_DONE;
              end
              MODE_SIM_CLEAR: begin
                sim_q     <= 1'b0;
                sampled_q <= 1'b1;
                state_q   <= ST_MUL;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end

        // sum * gain, low product bits shift out into low_q
        ST_MUL: begin
          acc_q  <= AccW'(mul_sum[MvW:1]);
          low_q  <= {mul_sum[0], low_q[MvW-1:1]};
          mplr_q <= mplr_q >> 1;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == MulLast) begin
            quo_q   <= {mul_sum[MvW:1], mul_sum[0], low_q[MvW-1:MvW-3]};
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end

        // product >> 12, divided by the oversampling count, saturated
        ST_DIV: begin
          rem_q <= div_rem;
          quo_q <= div_quo;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            raw_q <= meas_mv;
            cnt_q <= '0;
            acc_q <= '0;
            if (mode_q == MODE_UPDATE) begin
              mplr_q  <= alpha_clamp;
              wcomp_q <= ALPHA_ONE - alpha_clamp;
              state_q <= ST_EMA;
            end else begin
              filt_q  <= {meas_mv, 8'd0};
              state_q <= ST_CLS;
            end
          end
        end

        // weighted sum >> 16, last weight bit has unit scale and no shift
        ST_EMA: begin
          mplr_q  <= mplr_q >> 1;
          wcomp_q <= wcomp_q >> 1;
          cnt_q   <= cnt_q + 1'b1;
          if (cnt_q == EmaLast) begin
            filt_q  <= ema_sum[FiltW-1:0];
            state_q <= ST_CLS;
          end else begin
            acc_q <= ema_sum >> 1;
          end
        end

        ST_CLS: begin
          level_q <= level_next;
          state_q <= ST_DONE;
        end

        ST_DONE: begin
          if (out_free) state_q <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Output register; a finished result waits here for its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_filt_q    <= filt_q[FiltW-1:8];
      out_raw_q     <= raw_q;
      out_level_q   <= level_q;
      out_sim_q     <= sim_q;
      out_sampled_q <= sampled_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.filtered_mv = out_filt_q;
  assign out_o.raw_mv      = out_raw_q;
  assign out_o.level       = out_level_q;
  assign out_o.simulated   = out_sim_q;
  assign out_o.sampled     = out_sampled_q;

endmodule

`default_nettype wire

// File: hw/rtl/blm_checker.sv
// Port-level checks of the battery level monitor and their bind.
`default_nettype none

module blm_checker import blm_pkg::*; (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_i,
  input wire              out_valid_i,
  input wire              out_ready_i,
  input wire [MvW-1:0]    out_filt_i,
  input wire [MvW-1:0]    out_raw_i,
  input wire [LevelW-1:0] out_level_i,
  input wire              out_sim_i,
  input wire              out_sampled_i
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_filt_i) &&
      $stable(out_raw_i) && $stable(out_level_i) && $stable(out_sim_i) &&
      $stable(out_sampled_i))
    else $error("result changed while stalled");

  // One item at a time: input closes after each transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // A new result appears only when the sequencer has gone back to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result shown while still busy");

  // Level never takes the unused code
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_level_i != LVL_BAD)
    else $error("unused level code");

endmodule

bind battery_level_monitor_top blm_checker u_blm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_filt_i    (out_o.filtered_mv),
  .out_raw_i     (out_o.raw_mv),
  .out_level_i   (out_o.level),
  .out_sim_i     (out_o.simulated),
  .out_sampled_i (out_o.sampled)
);

`default_nettype wire
